/* hw/rtl/cbm_pkg.sv */
// Shared constants, types and command format for the cosine best-match table.
`default_nettype none

package cbm_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int VECTOR_LEN  = 384;

   localparam int ENT_W   = 4;
   localparam int ELEM_W  = 9;
   localparam int VAL_W   = 16;
   localparam int THR_W   = 15;
   localparam int SCORE_W = 16;
   localparam int DOT_W   = 41;
   localparam int NORM_W  = 40;

   localparam int MEM_DEPTH = NUM_ENTRIES * VECTOR_LEN;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int ECNT_W    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic signed [SCORE_W-1:0] ONE_Q       = 16'sd16384;
   localparam logic signed [SCORE_W-1:0] MINUS_ONE_Q = -16'sd16384;

   typedef enum logic [1:0] {
      OP_WRITE      = 2'd0,
      OP_INVALIDATE = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_QUERY      = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [ENT_W-1:0]         entry;
      logic [ELEM_W-1:0]        element;
      logic signed [VAL_W-1:0]  value;
      logic                     last;
      logic                     entry_ok;
      logic                     element_ok;
   } cmd_type;

   typedef struct packed {
      logic [DOT_W-1:0]  dot;
      logic [NORM_W-1:0] qn;
      logic [NORM_W-1:0] en;
   } score_req_type;

endpackage

`default_nettype wire

/* hw/rtl/cbm_req_if.sv */
// Request channel interface: valid/ready with one table request.
`default_nettype none

interface cbm_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        op;
   logic [cbm_pkg::ENT_W-1:0]         entry_index;
   logic [cbm_pkg::ELEM_W-1:0]        element_index;
   logic signed [cbm_pkg::VAL_W-1:0]  element_value;
   logic                              last;

   modport source (output valid, op, entry_index, element_index, element_value, last,
                   input ready);
   modport sink   (input valid, op, entry_index, element_index, element_value, last,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/cbm_rsp_if.sv */
// Response channel interface: valid/ready with one match result.
`default_nettype none

interface cbm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                matched;
   logic [cbm_pkg::ENT_W-1:0]           best_entry;
   logic signed [cbm_pkg::SCORE_W-1:0]  top_score;

   modport source (output valid, matched, best_entry, top_score, input ready);
   modport sink   (input valid, matched, best_entry, top_score, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cbm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 6144,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/cbm_score.sv */
// Iterative cosine score unit: two chunked products, then a bitwise root search.
`default_nettype none

module cbm_score (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire cbm_pkg::score_req_type        req,
   output logic                               done,
   output logic signed [cbm_pkg::SCORE_W-1:0] score
);

   localparam int CH_W   = 14;
   localparam int N_CH   = 3;
   localparam int B_W    = CH_W * N_CH;
   localparam int A_W    = cbm_pkg::DOT_W;
   localparam int PP_W   = A_W + CH_W;
   localparam int PROD_W = 2 * A_W;
   localparam int LO_W   = 15;
   localparam int SH     = 2 * (LO_W - 1);
   localparam int SRCH_W = PROD_W + SH + 2;
   localparam int K_W    = $clog2(LO_W);
   localparam int CHC_W  = $clog2(N_CH);

   typedef enum logic [1:0] {S_IDLE, S_MUL_P, S_MUL_R, S_SEARCH} state_type;

   state_type                   state_ff, state_in;
   logic                        neg_ff, neg_in;
   logic [A_W-1:0]              mag_ff, mag_in;
   logic [A_W-1:0]              a_ff, a_in;
   logic [B_W-1:0]              b_ff, b_in;
   logic [CHC_W-1:0]            chunk_ff, chunk_in;
   logic [PROD_W-1:0]           acc_ff, acc_in;
   logic [PROD_W-1:0]           p_ff, p_in;
   logic [SRCH_W-1:0]           asum_ff, asum_in;
   logic [SRCH_W-1:0]           bk_ff, bk_in;
   logic [SRCH_W-1:0]           pk_ff, pk_in;
   logic [SRCH_W-1:0]           r_ff, r_in;
   logic [K_W-1:0]              k_ff, k_in;
   logic [LO_W-1:0]             lo_ff, lo_in;
   logic                        done_ff, done_in;
   logic signed [cbm_pkg::SCORE_W-1:0] score_ff, score_in;

   logic [PP_W-1:0]   pp;
   logic [PROD_W-1:0] acc_next;
   logic [SRCH_W-1:0] cand;
   logic              fits;
   logic [LO_W-1:0]   lo_next;
   logic [LO_W-1:0]   lo_cap;
   logic [cbm_pkg::SCORE_W-1:0] mag16;

   assign pp       = a_ff * b_ff[B_W-1 -: CH_W];
   assign acc_next = (acc_ff << CH_W) + PROD_W'(pp);
   assign cand     = asum_ff + bk_ff + pk_ff;
   assign fits     = (cand <= r_ff);
   assign lo_next  = fits ? (lo_ff | (LO_W'(1) << k_ff)) : lo_ff;
   assign lo_cap   = (lo_next > LO_W'(cbm_pkg::ONE_Q)) ? LO_W'(cbm_pkg::ONE_Q) : lo_next;
   assign mag16    = cbm_pkg::SCORE_W'(lo_cap);

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      chunk_in = chunk_ff;
      acc_in   = acc_ff;
      p_in     = p_ff;
      asum_in  = asum_ff;
      bk_in    = bk_ff;
      pk_in    = pk_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      lo_in    = lo_ff;
      done_in  = 1'b0;
      score_in = score_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req.qn == '0 || req.en == '0) begin
                  score_in = '0;
                  done_in  = 1'b1;
               end else begin
                  neg_in   = req.dot[A_W-1];
                  mag_in   = req.dot[A_W-1] ? (~req.dot + A_W'(1)) : req.dot;
                  a_in     = A_W'(req.qn);
                  b_in     = B_W'(req.en);
                  acc_in   = '0;
                  chunk_in = '0;
                  state_in = S_MUL_P;
               end
            end
         end
         S_MUL_P: begin
            acc_in   = acc_next;
            b_in     = b_ff << CH_W;
            chunk_in = chunk_ff + CHC_W'(1);
            if (chunk_ff == CHC_W'(N_CH - 1)) begin
               p_in     = acc_next;
               a_in     = mag_ff;
               b_in     = B_W'(mag_ff);
               acc_in   = '0;
               chunk_in = '0;
               state_in = S_MUL_R;
            end
         end
         S_MUL_R: begin
            acc_in   = acc_next;
            b_in     = b_ff << CH_W;
            chunk_in = chunk_ff + CHC_W'(1);
            if (chunk_ff == CHC_W'(N_CH - 1)) begin
               r_in     = SRCH_W'(acc_next) << SH;
               pk_in    = SRCH_W'(p_ff) << SH;
               bk_in    = '0;
               asum_in  = '0;
               k_in     = K_W'(LO_W - 1);
               lo_in    = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            lo_in = lo_next;
            if (fits) begin
               asum_in = cand;
               bk_in   = (bk_ff + (pk_ff << 1)) >> 1;
            end else begin
               bk_in   = bk_ff >> 1;
            end
            pk_in = pk_ff >> 2;
            k_in  = k_ff - K_W'(1);
            if (k_ff == '0) begin
               score_in = neg_ff ? (cbm_pkg::SCORE_W'(0) - mag16) : mag16;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      chunk_ff <= chunk_in;
      acc_ff   <= acc_in;
      p_ff     <= p_in;
      asum_ff  <= asum_in;
      bk_ff    <= bk_in;
      pk_ff    <= pk_in;
      r_ff     <= r_in;
      k_ff     <= k_in;
      lo_ff    <= lo_in;
      score_ff <= score_in;
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done  = done_ff;
   assign score = score_ff;

`ifndef NO_ASSERTIONS
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (score_ff <= cbm_pkg::ONE_Q && score_ff >= cbm_pkg::MINUS_ONE_Q))
      else $error("score out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("score start while busy");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cbm_front.sv */
// Front end: accepts requests, range-checks them and queues decoded commands.
`default_nettype none

module cbm_front (
   input  wire logic          clock,
   input  wire logic          reset,
   cbm_req_if.sink            req,
   output cbm_pkg::cmd_type   cmd,
   output logic               cmd_valid,
   input  wire logic          cmd_pop
);

   cbm_pkg::cmd_type            slots_ff [cbm_pkg::QDEPTH];
   cbm_pkg::cmd_type            slots_in [cbm_pkg::QDEPTH];
   logic [cbm_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cbm_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cbm_pkg::QCNT_W-1:0]  count_ff, count_in;

   cbm_pkg::cmd_type new_cmd;
   logic             push;
   logic             pop;

   always_comb begin
      new_cmd.op         = cbm_pkg::op_type'(req.op);
      new_cmd.entry      = req.entry_index;
      new_cmd.element    = req.element_index;
      new_cmd.value      = req.element_value;
      new_cmd.last       = req.last;
      new_cmd.entry_ok   = (32'(req.entry_index) < cbm_pkg::NUM_ENTRIES);
      new_cmd.element_ok = (32'(req.element_index) < cbm_pkg::VECTOR_LEN);
   end

   assign req.ready = (count_ff != cbm_pkg::QCNT_W'(cbm_pkg::QDEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = slots_ff[rd_ptr_ff];

   always_comb begin
      slots_in  = slots_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         slots_in[wr_ptr_ff] = new_cmd;
         wr_ptr_in = (wr_ptr_ff == cbm_pkg::QPTR_W'(cbm_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + cbm_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cbm_pkg::QPTR_W'(cbm_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + cbm_pkg::QPTR_W'(1);
      end
      count_in = count_ff + cbm_pkg::QCNT_W'(push) - cbm_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cbm_pkg::QCNT_W'(cbm_pkg::QDEPTH))
      else $error("command queue overflow");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cbm_back.sv */
// Back end: table storage, per-entry accumulation sweep, scoring scan and result register.
`default_nettype none

module cbm_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cbm_pkg::cmd_type           cmd,
   input  wire logic                       cmd_valid,
   output logic                            cmd_pop,
   input  wire logic [cbm_pkg::THR_W-1:0]  threshold,
   cbm_rsp_if.source                       rsp
);

   localparam int NE  = cbm_pkg::NUM_ENTRIES;
   localparam int EW  = cbm_pkg::ECNT_W;
   localparam int AW  = cbm_pkg::ADDR_W;
   localparam int DW  = cbm_pkg::DOT_W;
   localparam int NW  = cbm_pkg::NORM_W;
   localparam int SW  = cbm_pkg::SCORE_W;
   localparam int PW  = 2 * cbm_pkg::VAL_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SWEEP, ST_DRAIN, ST_SCAN, ST_WAIT, ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   cbm_pkg::cmd_type   cur_ff, cur_in;
   logic [EW-1:0]      issue_ff, issue_in;
   logic [EW-1:0]      scan_ff, scan_in;
   logic [NE-1:0]      valid_ff, valid_in;
   logic [NW-1:0]      qnorm_ff, qnorm_in;
   logic [DW-1:0]      dot_ff [NE];
   logic [DW-1:0]      dot_in [NE];
   logic [NW-1:0]      enorm_ff [NE];
   logic [NW-1:0]      enorm_in [NE];
   logic               p1_v_ff, p1_v_in;
   logic [EW-1:0]      p1_e_ff, p1_e_in;
   logic               p2_v_ff, p2_v_in;
   logic [EW-1:0]      p2_e_ff, p2_e_in;
   logic signed [PW-1:0] p2_dot_ff, p2_dot_in;
   logic signed [PW-1:0] p2_nrm_ff, p2_nrm_in;
   logic signed [SW-1:0] best_ff, best_in;
   logic [EW-1:0]      best_idx_ff, best_idx_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_matched_ff, rsp_matched_in;
   logic [cbm_pkg::ENT_W-1:0] rsp_entry_ff, rsp_entry_in;
   logic signed [SW-1:0] rsp_score_ff, rsp_score_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   logic [cbm_pkg::VAL_W-1:0] ram_rdata;
   logic signed [cbm_pkg::VAL_W-1:0] r_val;
   logic signed [PW-1:0] q_sq;
   logic                 scan_adv;
   logic                 score_start;
   logic                 score_done;
   logic signed [SW-1:0] score_val;
   cbm_pkg::score_req_type score_req;

   assign ram_waddr = AW'(32'(cmd.entry) * cbm_pkg::VECTOR_LEN) + AW'(cmd.element);
   assign ram_raddr = AW'(32'(issue_ff) * cbm_pkg::VECTOR_LEN) + AW'(cur_ff.element);
   assign r_val     = $signed(ram_rdata);
   assign q_sq      = cmd.value * cmd.value;

   cbm_ram #(.WIDTH(cbm_pkg::VAL_W), .DEPTH(cbm_pkg::MEM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign score_req.dot = dot_ff[scan_ff];
   assign score_req.qn  = qnorm_ff;
   assign score_req.en  = enorm_ff[scan_ff];

   cbm_score u_score (
      .clock (clock),
      .reset (reset),
      .start (score_start),
      .req   (score_req),
      .done  (score_done),
      .score (score_val)
   );

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      issue_in       = issue_ff;
      scan_in        = scan_ff;
      valid_in       = valid_ff;
      qnorm_in       = qnorm_ff;
      dot_in         = dot_ff;
      enorm_in       = enorm_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_score_in   = rsp_score_ff;
      cmd_pop        = 1'b0;
      ram_we         = 1'b0;
      score_start    = 1'b0;
      scan_adv       = 1'b0;

      p1_v_in   = (state_ff == ST_SWEEP);
      p1_e_in   = issue_ff;
      p2_v_in   = p1_v_ff;
      p2_e_in   = p1_e_ff;
      p2_dot_in = cur_ff.value * r_val;
      p2_nrm_in = r_val * r_val;

      if (p2_v_ff) begin
         dot_in[p2_e_ff]   = dot_ff[p2_e_ff] + DW'(p2_dot_ff);
         enorm_in[p2_e_ff] = enorm_ff[p2_e_ff] + NW'(p2_nrm_ff);
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               case (cmd.op)
                  cbm_pkg::OP_WRITE: begin
                     if (cmd.entry_ok && cmd.element_ok) begin
                        ram_we = 1'b1;
                        valid_in[EW'(cmd.entry)] = 1'b1;
                     end
                  end
                  cbm_pkg::OP_INVALIDATE: begin
                     if (cmd.entry_ok) begin
                        valid_in[EW'(cmd.entry)] = 1'b0;
                     end
                  end
                  cbm_pkg::OP_CLEAR: begin
                     valid_in = '0;
                  end
                  cbm_pkg::OP_QUERY: begin
                     if (cmd.element_ok) begin
                        qnorm_in = qnorm_ff + NW'(q_sq);
                        issue_in = '0;
                        state_in = ST_SWEEP;
                     end else if (cmd.last) begin
                        scan_in     = '0;
                        best_in     = cbm_pkg::MINUS_ONE_Q;
                        best_idx_in = '0;
                        found_in    = 1'b0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            issue_in = issue_ff + EW'(1);
            if (issue_ff == EW'(NE - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff) begin
               if (cur_ff.last) begin
                  scan_in     = '0;
                  best_in     = cbm_pkg::MINUS_ONE_Q;
                  best_idx_in = '0;
                  found_in    = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (valid_ff[scan_ff]) begin
               score_start = 1'b1;
               state_in    = ST_WAIT;
            end else begin
               scan_adv = 1'b1;
            end
         end
         ST_WAIT: begin
            if (score_done) begin
               if (score_val > best_ff) begin
                  best_in     = score_val;
                  best_idx_in = scan_ff;
                  found_in    = 1'b1;
               end
               scan_adv = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = found_ff && (best_ff >= $signed({1'b0, threshold}));
               rsp_entry_in   = cbm_pkg::ENT_W'(best_idx_ff);
               rsp_score_in   = best_ff;
               qnorm_in       = '0;
               for (int i = 0; i < NE; i++) begin
                  dot_in[i]   = '0;
                  enorm_in[i] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_adv) begin
         if (scan_ff == EW'(NE - 1)) begin
            state_in = ST_EMIT;
         end else begin
            scan_in  = scan_ff + EW'(1);
            state_in = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      issue_ff       <= issue_in;
      scan_ff        <= scan_in;
      p1_e_ff        <= p1_e_in;
      p2_e_ff        <= p2_e_in;
      p2_dot_ff      <= p2_dot_in;
      p2_nrm_ff      <= p2_nrm_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_score_ff   <= rsp_score_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         qnorm_ff     <= '0;
         for (int i = 0; i < NE; i++) begin
            dot_ff[i]   <= '0;
            enorm_ff[i] <= '0;
         end
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         qnorm_ff     <= qnorm_in;
         dot_ff       <= dot_in;
         enorm_ff     <= enorm_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p2_v_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.matched    = rsp_matched_ff;
   assign rsp.best_entry = rsp_entry_ff;
   assign rsp.top_score  = rsp_score_ff;

`ifndef NO_ASSERTIONS
   a_scan_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_WAIT) |-> (!p1_v_ff && !p2_v_ff))
      else $error("scoring overlaps accumulation");
   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE && cmd_valid))
      else $error("command taken while busy");
   a_emit_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_score_ff == $past(rsp_score_ff)))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cosine_best_match_table.sv */
// Top level of the cosine best-match table.
`default_nettype none

// Holds 16 reference vectors of 384 Q1.15 elements in one RAM and scores a
// streamed query against every valid entry. Table writes, invalidates and
// clear-all requests are done as the back end takes the command. A query
// element is handled by taking the command, one RAM read per entry for all 16
// entries from the single read port, and a multiply-accumulate drain. A last
// query element then scans the entries; a valid entry is scored by a start,
// two three-chunk products, a 15-step root search and the return (zero if
// either norm is zero), an invalid one is skipped, and the result register
// loads once any earlier result is taken. A two-deep command queue lets
// requests be accepted while the back end is busy, and a response register
// holds the result until it is taken. The user must write match_threshold
// through csr_wr_en/csr_wr_data only while idle; the block does not enforce it.
module cosine_best_match_table (
   input  wire logic                       clock,
   input  wire logic                       reset,
   cbm_req_if.sink                         req_chan,
   cbm_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [cbm_pkg::THR_W-1:0]  csr_wr_data
);

   logic [cbm_pkg::THR_W-1:0] threshold_ff, threshold_in;
   cbm_pkg::cmd_type          cmd;
   logic                      cmd_valid;
   logic                      cmd_pop;

   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   cbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   cbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .threshold (threshold_ff),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

/* dv/cbm_checker.sv */
// Checker for the cosine best-match table: predicts match results and compares them.
`timescale 1ns / 1ps

module cbm_checker (
   input  logic                       clock,
   input  logic                       reset,
   cbm_req_if                         req_mon,
   cbm_rsp_if                         rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [cbm_pkg::THR_W-1:0]  csr_wr_data,
   output int                         fail_count,
   output int                         pending
);
   import cbm_pkg::*;

   typedef struct packed {
      logic                       matched;
      logic [ENT_W-1:0]           best_entry;
      logic signed [SCORE_W-1:0]  top_score;
   } match_t;

   logic [VAL_W-1:0]   ref_vec [MEM_DEPTH];
   logic               ent_valid [NUM_ENTRIES];
   logic [DOT_W-1:0]   dot_acc [NUM_ENTRIES];
   logic [NORM_W-1:0]  enorm_acc [NUM_ENTRIES];
   logic [NORM_W-1:0]  qnorm_acc;
   logic [THR_W-1:0]   threshold;
   match_t             expected_matches [$];

   function automatic int cosine_q14(logic [DOT_W-1:0] dot, logic [NORM_W-1:0] qn,
                                     logic [NORM_W-1:0] en);
      logic          neg;
      logic [127:0]  mag, x, rhs, prod;
      int            lo, hi, mid;
      neg = dot[DOT_W-1];
      mag = neg ? 128'((~dot + 1'b1) & {DOT_W{1'b1}}) : 128'(dot);
      lo = 0;
      hi = ONE_Q;
      if (qn == 0 || en == 0) return 0;
      if (mag == 0 && neg) mag = 128'(1) << 40;
      x = mag << 14;
      rhs = x * x;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         prod = 128'(mid) * 128'(mid) * 128'(qn) * 128'(en);
         if (prod <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return neg ? -lo : lo;
   endfunction

   task automatic apply_request();
      op_type  op;
      int      q, r, s, best, best_idx;
      bit      found;
      match_t  m;
      op = op_type'(req_mon.op);
      case (op)
         OP_WRITE: begin
            if (req_mon.element_index < VECTOR_LEN) begin
               ref_vec[req_mon.entry_index * VECTOR_LEN + req_mon.element_index] =
                  req_mon.element_value;
               ent_valid[req_mon.entry_index] = 1'b1;
            end
         end
         OP_INVALIDATE: ent_valid[req_mon.entry_index] = 1'b0;
         OP_CLEAR: foreach (ent_valid[e]) ent_valid[e] = 1'b0;
         OP_QUERY: begin
            if (req_mon.element_index < VECTOR_LEN) begin
               q = req_mon.element_value;
               qnorm_acc = qnorm_acc + NORM_W'(q * q);
               for (int e = 0; e < NUM_ENTRIES; e++) begin
                  r = $signed(ref_vec[e * VECTOR_LEN + req_mon.element_index]);
                  dot_acc[e] = dot_acc[e] + DOT_W'(q * r);
                  enorm_acc[e] = enorm_acc[e] + NORM_W'(r * r);
               end
            end
            if (req_mon.last) begin
               best = -ONE_Q;
               best_idx = 0;
               found = 0;
               for (int e = 0; e < NUM_ENTRIES; e++) begin
                  if (ent_valid[e]) begin
                     s = cosine_q14(dot_acc[e], qnorm_acc, enorm_acc[e]);
                     if (s > best) begin
                        best = s;
                        best_idx = e;
                        found = 1;
                     end
                  end
               end
               m.matched = found && (best >= int'(threshold));
               m.best_entry = ENT_W'(best_idx);
               m.top_score = SCORE_W'(best);
               expected_matches = {expected_matches, m};
               foreach (dot_acc[e]) begin
                  dot_acc[e] = '0;
                  enorm_acc[e] = '0;
               end
               qnorm_acc = '0;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_match();
      match_t exp_m;
      if (expected_matches.size() == 0) begin
         $display("%0t: unexpected match result: matched=%0d entry=%0d score=%0d", $time,
                  rsp_mon.matched, rsp_mon.best_entry, rsp_mon.top_score);
         fail_count++;
         return;
      end
      exp_m = expected_matches.pop_front();
      if (rsp_mon.matched !== exp_m.matched) begin
         $display("%0t: matched mismatch: expected %0d actual %0d", $time,
                  exp_m.matched, rsp_mon.matched);
         fail_count++;
      end
      if (rsp_mon.best_entry !== exp_m.best_entry) begin
         $display("%0t: best_entry mismatch: expected %0d actual %0d", $time,
                  exp_m.best_entry, rsp_mon.best_entry);
         fail_count++;
      end
      if (rsp_mon.top_score !== exp_m.top_score) begin
         $display("%0t: top_score mismatch: expected %0d actual %0d", $time,
                  exp_m.top_score, rsp_mon.top_score);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         foreach (ent_valid[e]) begin
            ent_valid[e] = 1'b0;
            dot_acc[e] = '0;
            enorm_acc[e] = '0;
         end
         qnorm_acc = '0;
         threshold = '0;
         expected_matches.delete();
      end else begin
         if (csr_wr_en) threshold = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) check_match();
         if (req_mon.valid && req_mon.ready) apply_request();
      end
      pending = expected_matches.size();
   end

endmodule

/* dv/tb_cosine_best_match_table.sv */
// Testbench top for the cosine best-match table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_cosine_best_match_table;
   import cbm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 1400;
   localparam int PRELOAD_ELEMS = 8;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [THR_W-1:0]    csr_wr_data;
   int                  fail_count;
   int                  pending;
   int                  items_sent;
   int                  matches_taken;
   bit                  steady;
   logic [15:0]         written_map [512];
   logic [VAL_W-1:0]    shadow_vec [NUM_ENTRIES * 512];
   int                  usable_elems [$];

   cbm_req_if req_chan ();
   cbm_rsp_if rsp_chan ();

   cosine_best_match_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cbm_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_request(op_type op, int ent, int el, int val, bit last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.op = op;
      req_chan.entry_index = ENT_W'(ent);
      req_chan.element_index = ELEM_W'(el);
      req_chan.element_value = VAL_W'(val);
      req_chan.last = last;
      req_chan.valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (op == OP_WRITE && el < 512) begin
         shadow_vec[ent * 512 + el] = VAL_W'(val);
         if (el < VECTOR_LEN && written_map[el] != 16'hFFFF) begin
            written_map[el][ent] = 1'b1;
            if (written_map[el] == 16'hFFFF) usable_elems = {usable_elems, el};
         end
      end
   endtask

   task automatic write_threshold(int value);
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      csr_wr_data = THR_W'(value);
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic query_sequence();
      int len, target, el, val;
      len = $urandom_range(1, 6);
      target = $urandom_range(0, NUM_ENTRIES - 1);
      for (int i = 0; i < len; i++) begin
         if (usable_elems.size() > 0 && $urandom_range(0, 9) != 0)
            el = usable_elems[$urandom_range(0, usable_elems.size() - 1)];
         else
            el = $urandom_range(VECTOR_LEN, 511);
         case ($urandom_range(0, 3))
            0, 1: val = shadow_vec[target * 512 + el];
            2: val = $urandom_range(0, 65535);
            default: val = -int'($signed(shadow_vec[target * 512 + el]));
         endcase
         send_request(OP_QUERY, 0, el, val, i == len - 1);
      end
   endtask

   // rsp side: random stalls plus one long hold-off to back up the input
   initial begin
      bit held;
      int stall;
      held = 0;
      matches_taken = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (matches_taken == 8 && !held) begin
            rsp_chan.ready = 1'b0;
            repeat (3000) @(negedge clock);
            held = 1;
         end
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         matches_taken++;
         @(negedge clock);
      end
   end

   initial begin
      int thresholds [5];
      int pick;
      thresholds = '{0, 16384, 32767, 0, 12000};
      thresholds[3] = $urandom_range(1, 16383);
      items_sent = 0;
      steady = 0;
      foreach (written_map[i]) written_map[i] = '0;
      foreach (shadow_vec[i]) shadow_vec[i] = '0;
      req_chan.valid = 1'b0;
      req_chan.op = OP_WRITE;
      req_chan.entry_index = '0;
      req_chan.element_index = '0;
      req_chan.element_value = '0;
      req_chan.last = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      write_threshold(thresholds[0]);
      // directed: empty table, extremes, zero magnitude, out-of-range, clear, stray last
      send_request(OP_QUERY, 0, 400, 32767, 1'b1);
      for (int e = 0; e < NUM_ENTRIES; e++)
         send_request(OP_WRITE, e, 0,
                      e == 0 ? -32768 : e == 1 ? 32767 : e == 2 ? 16384 : e == 3 ? 0 :
                      int'($urandom_range(0, 65535)), 1'b0);
      send_request(OP_WRITE, 5, 450, 1234, 1'b1);
      send_request(OP_QUERY, 0, 0, 32767, 1'b1);
      send_request(OP_INVALIDATE, 1, 0, 0, 1'b1);
      send_request(OP_QUERY, 0, 0, -32768, 1'b1);
      send_request(OP_QUERY, 0, 0, 0, 1'b1);
      send_request(OP_CLEAR, 0, 0, 0, 1'b1);
      send_request(OP_QUERY, 0, 511, -1, 1'b1);

      for (int el = 1; el < PRELOAD_ELEMS; el++)
         for (int e = 0; e < NUM_ENTRIES; e++)
            send_request(OP_WRITE, e, el, $urandom_range(0, 65535), 1'b0);

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) write_threshold(thresholds[ph]);
         while (items_sent < (ph + 1) * ITEM_TARGET / 5) begin
            if ($urandom_range(0, 99) == 0) steady = !steady;
            pick = $urandom_range(0, 99);
            if (pick < 55)
               query_sequence();
            else if (pick < 85)
               send_request(OP_WRITE, $urandom_range(0, NUM_ENTRIES - 1),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) :
                            $urandom_range(0, PRELOAD_ELEMS + 7),
                            $urandom_range(0, 65535), $urandom_range(0, 1));
            else if (pick < 95)
               send_request(OP_INVALIDATE, $urandom_range(0, NUM_ENTRIES - 1),
                            $urandom_range(0, 511), $urandom_range(0, 65535),
                            $urandom_range(0, 1));
            else
               send_request(OP_CLEAR, $urandom_range(0, NUM_ENTRIES - 1),
                            $urandom_range(0, 511), $urandom_range(0, 65535),
                            $urandom_range(0, 1));
         end
      end

      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
